[rtl/mpi_pkg.sv]
package mpi_pkg;

    // Field widths of the request and the response.
    localparam int unsigned BASE_W = 30;
    localparam int unsigned EXP_W  = 31;
    localparam int unsigned PROD_W = 2 * BASE_W;

    // The prime modulus and the exponent used for the Fermat inverse.
    localparam logic [BASE_W-1:0] PRIME_MOD  = 30'd998244353;
    localparam logic [EXP_W-1:0]  FERMAT_EXP = 31'(64'(PRIME_MOD) - 64'd2);

    // Barrett constant floor(2^60 / prime); it fits in 31 bits.
    localparam logic [63:0] MU_FULL    = 64'h1000_0000_0000_0000 / 64'(PRIME_MOD);
    localparam logic [30:0] BARRETT_MU = MU_FULL[30:0];

    // Operation tags carried alongside each multiply through the pipeline.
    typedef logic tag_t;
    localparam tag_t TAG_SQUARE   = 1'b0;
    localparam tag_t TAG_MULTIPLY = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [BASE_W-1:0] base;
        logic [EXP_W-1:0]  exponent;
    } req_t;

    typedef struct packed {
        logic [BASE_W-1:0] result;
    } rsp_t;

    // Issue of one modular multiply to the shared unit.
    typedef struct packed {
        logic              valid;
        tag_t              tag;
        logic [BASE_W-1:0] a;
        logic [BASE_W-1:0] b;
    } mm_issue_t;

    // Completion of one modular multiply.
    typedef struct packed {
        logic              valid;
        tag_t              tag;
        logic [BASE_W-1:0] value;
    } mm_result_t;

endpackage

[rtl/mpi_stream_if.sv]
interface mpi_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/mpi_modmul.sv]
module mpi_modmul (
    input  logic                clk,
    input  logic                rst_n,
    input  mpi_pkg::mm_issue_t  issue,
    output mpi_pkg::mm_result_t done
);
    import mpi_pkg::*;

    // Four-stage Barrett multiplier: product, quotient estimate, quotient
    // times prime, then subtraction with up to two corrections.
    logic              s1_valid_reg;
    tag_t              s1_tag_reg;
    logic [PROD_W-1:0] s1_prod_reg;

    logic              s2_valid_reg;
    tag_t              s2_tag_reg;
    logic [31:0]       s2_lo_reg;
    logic [61:0]       s2_q2_reg;

    logic              s3_valid_reg;
    tag_t              s3_tag_reg;
    logic [31:0]       s3_lo_reg;
    logic [31:0]       s3_qp_reg;

    logic              done_valid_reg;
    tag_t              done_tag_reg;
    logic [BASE_W-1:0] done_value_reg;

    logic [30:0]       q1;
    logic [30:0]       q3;
    logic [60:0]       qp_full;
    logic [31:0]       rem;
    logic [31:0]       rem_1p;
    logic [31:0]       rem_2p;
    logic [31:0]       prime_1p;
    logic [31:0]       prime_2p;
    logic [BASE_W-1:0] rem_fixed;

    assign q1       = s1_prod_reg[PROD_W-1:29];
    assign q3       = s2_q2_reg[61:31];
    assign qp_full  = 61'(q3) * 61'(PRIME_MOD);
    assign prime_1p = 32'(PRIME_MOD);
    assign prime_2p = {1'b0, PRIME_MOD, 1'b0};
    assign rem      = s3_lo_reg - s3_qp_reg;
    assign rem_1p   = rem - prime_1p;
    assign rem_2p   = rem - prime_2p;

    always_comb
    begin
        if (rem >= prime_2p)
        begin
            rem_fixed = rem_2p[BASE_W-1:0];
        end
        else if (rem >= prime_1p)
        begin
            rem_fixed = rem_1p[BASE_W-1:0];
        end
        else
        begin
            rem_fixed = rem[BASE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            done_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= issue.valid;
            s2_valid_reg   <= s1_valid_reg;
            s3_valid_reg   <= s2_valid_reg;
            done_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg     <= issue.tag;
        s1_prod_reg    <= PROD_W'(issue.a) * PROD_W'(issue.b);
        s2_tag_reg     <= s1_tag_reg;
        s2_lo_reg      <= s1_prod_reg[31:0];
        s2_q2_reg      <= 62'(q1) * 62'(BARRETT_MU);
        s3_tag_reg     <= s2_tag_reg;
        s3_lo_reg      <= s2_lo_reg;
        s3_qp_reg      <= qp_full[31:0];
        done_tag_reg   <= s3_tag_reg;
        done_value_reg <= rem_fixed;
    end

    assign done.valid = done_valid_reg;
    assign done.tag   = done_tag_reg;
    assign done.value = done_value_reg;

endmodule

[rtl/modular_power_and_inverse_unit.sv]
// Each exponent bit costs a square through the shared four-stage multiplier, and a set
// bit adds a multiply into the accumulator.
// One request is handled at a time: a new request beat is taken only in the idle state,
// which is entered in the cycle after the result beat is accepted.
// Reset is asynchronous and active low; it idles the sequencer and empties the pipeline.
module modular_power_and_inverse_unit (
    input  logic         clk,
    input  logic         rst_n,
    mpi_stream_if.sink   req,
    mpi_stream_if.source rsp
);
    import mpi_pkg::*;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOOP  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [BASE_W-1:0] base_reg;
    logic [BASE_W-1:0] base_next;
    logic [BASE_W-1:0] acc_reg;
    logic [BASE_W-1:0] acc_next;
    logic [EXP_W-1:0]  exp_reg;
    logic [EXP_W-1:0]  exp_next;
    logic [1:0]        pending_reg;
    logic [1:0]        pending_next;

    req_t              req_beat;
    rsp_t              rsp_beat;
    logic              req_fire;
    logic [BASE_W-1:0] base_reduced;
    mm_issue_t         mm_issue;
    mm_result_t        mm_done;

    mpi_modmul u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .issue (mm_issue),
        .done  (mm_done)
    );

    assign req_beat  = req.payload;
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    // A 30-bit base lies below twice the prime, so one subtraction reduces it.
    assign base_reduced = (req_beat.base >= PRIME_MOD) ? (req_beat.base - PRIME_MOD)
                                                       : req_beat.base;

    always_comb
    begin
        state_next   = state_reg;
        base_next    = base_reg;
        acc_next     = acc_reg;
        exp_next     = exp_reg;
        mm_issue     = '{valid: 1'b0, tag: TAG_SQUARE, a: base_reg, b: base_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    base_next  = base_reduced;
                    acc_next   = BASE_W'(1);
                    exp_next   = req_beat.mode ? FERMAT_EXP : req_beat.exponent;
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                // Once every exponent bit has been consumed the accumulator is the answer.
                if (exp_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mm_issue.valid = 1'b1;
                    state_next     = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // The square is still in flight, so base_reg is the old base here.
                if (exp_reg[0])
                begin
                    mm_issue = '{valid: 1'b1, tag: TAG_MULTIPLY, a: acc_reg, b: base_reg};
                end
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (pending_reg == '0)
                begin
                    exp_next   = exp_reg >> 1;
                    state_next = ST_LOOP;
                end
            end
            ST_DONE:
            begin
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Completed products land in the register their tag names.
        if (mm_done.valid)
        begin
            if (mm_done.tag == TAG_MULTIPLY)
            begin
                acc_next = mm_done.value;
            end
            else
            begin
                base_next = mm_done.value;
            end
        end

        pending_next = pending_reg + 2'(mm_issue.valid) - 2'(mm_done.valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pending_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        acc_reg  <= acc_next;
        exp_reg  <= exp_next;
    end

    // The accumulator doubles as the output register while the result beat waits.
    assign rsp_beat.result = acc_reg;
    assign rsp.payload     = rsp_beat;
    assign rsp.valid       = (state_reg == ST_DONE);

endmodule

[dv/modular_power_and_inverse_unit_test.sv]
module modular_power_and_inverse_unit_test;

    import mpi_pkg::*;

    // The drain at the end and the watchdog are sized from the longest latency of one request.
    localparam int unsigned DRAIN_CYCLES  = 250;
    localparam int unsigned QUIET_LIMIT   = 5000;
    localparam int unsigned LONG_HOLD     = 600;
    localparam int unsigned RANDOM_PER_PHASE = 430;
    localparam int unsigned SHOWN_FAULTS  = 10;

    logic clk;
    logic rst_n;

    mpi_stream_if #(.payload_t(req_t)) req_if ();
    mpi_stream_if #(.payload_t(rsp_t)) rsp_if ();

    modular_power_and_inverse_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Requests waiting to be offered, and the residues that accepted requests must
    // produce, oldest first.
    req_t              pending_requests[$];
    logic [BASE_W-1:0] expected_residues[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_orders;
    int unsigned hold_served;
    int unsigned hold_left;
    int unsigned fault_count;
    int unsigned quiet_cycles;

    always #5 clk = ~clk;

    // Right-to-left square-and-multiply modulo the prime. The base is reduced first,
    // so operands at or above the prime give the same answer as their residue. Every
    // product of two residues is below 2^60 and fits comfortably in 64 bits.
    function automatic logic [BASE_W-1:0] power_residue(input logic [BASE_W-1:0] base,
                                                        input logic [EXP_W-1:0] exponent);
        logic [63:0]      acc;
        logic [63:0]      square;
        logic [EXP_W-1:0] e;
        acc    = 64'd1;
        square = 64'(base) % 64'(PRIME_MOD);
        e      = exponent;
        while (e != '0)
        begin
            if (e[0])
            begin
                acc = (acc * square) % 64'(PRIME_MOD);
            end
            square = (square * square) % 64'(PRIME_MOD);
            e      = e >> 1;
        end
        return acc[BASE_W-1:0];
    endfunction

    // The inverse is the base raised to the prime minus two; the exponent field is
    // then of no account, and an inverse of zero simply comes out as zero.
    function automatic logic [BASE_W-1:0] predict_residue(input req_t request);
        if (request.mode)
        begin
            return power_residue(request.base, FERMAT_EXP);
        end
        return power_residue(request.base, request.exponent);
    endfunction

    task automatic queue_request(input logic mode, input logic [BASE_W-1:0] base,
                                 input logic [EXP_W-1:0] exponent);
        req_t request;
        request.mode     = mode;
        request.base     = base;
        request.exponent = exponent;
        pending_requests.push_back(request);
    endtask

    // Random requests lean towards proper residues and long exponents, which keep the
    // sequencer busiest, but bases above the prime, tiny bases and short exponents
    // are mixed in so that every bit of every field is exercised both ways.
    task automatic queue_random_request();
        logic              mode;
        logic [BASE_W-1:0] base;
        logic [EXP_W-1:0]  exponent;
        int unsigned       pick;
        mode = ($urandom_range(99) < 30);
        pick = $urandom_range(99);
        if (pick < 65)
        begin
            base = BASE_W'($urandom_range(PRIME_MOD - 1, 0));
        end
        else if (pick < 78)
        begin
            base = BASE_W'($urandom_range(30'h3FFF_FFFF, PRIME_MOD));
        end
        else if (pick < 89)
        begin
            base = BASE_W'($urandom_range(15));
        end
        else
        begin
            base = PRIME_MOD - BASE_W'($urandom_range(16, 1));
        end
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            exponent = EXP_W'($urandom);
        end
        else if (pick < 70)
        begin
            exponent = EXP_W'($urandom_range(63));
        end
        else
        begin
            exponent = EXP_W'($urandom >> $urandom_range(31, 1));
        end
        queue_request(mode, base, exponent);
    endtask

    // Waits, between falling edges, until no request is queued or on offer and every
    // expected result has been seen.
    task automatic wait_until_idle();
        while (pending_requests.size() != 0 || req_if.valid || expected_residues.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Request driver. A beat stays on offer until it is taken; a new one is only
    // loaded once the previous beat has gone, so valid is written once per edge.
    // The expectation is recorded at the very edge at which the beat is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid   <= 1'b0;
            req_if.payload <= '0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                expected_residues.push_back(predict_residue(req_if.payload));
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_if.payload <= pending_requests.pop_front();
                    req_if.valid   <= 1'b1;
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver. A long hold-off is ordered from the stimulus by bumping
    // hold_orders; the count of remaining cycles is kept here alone.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            hold_left    <= 0;
            hold_served  <= 0;
        end
        else if (hold_orders != hold_served)
        begin
            hold_served  <= hold_orders;
            hold_left    <= LONG_HOLD;
            rsp_if.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result monitor: each accepted result beat is matched against the oldest
    // outstanding expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_residues.size() == 0)
            begin
                if (fault_count < SHOWN_FAULTS)
                begin
                    $display("unexpected result beat: result=%0d", rsp_if.payload.result);
                end
                fault_count <= fault_count + 1;
            end
            else
            begin
                logic [BASE_W-1:0] wanted;
                wanted = expected_residues.pop_front();
                if (rsp_if.payload.result !== wanted)
                begin
                    if (fault_count < SHOWN_FAULTS)
                    begin
                        $display("result mismatch: expected=%0d actual=%0d",
                                 wanted, rsp_if.payload.result);
                    end
                    fault_count <= fault_count + 1;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither side moves a beat.
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no beat accepted for %0d cycles", quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        send_idle_pct  = 24;
        recv_idle_pct  = 82;
        hold_orders    = 0;
        fault_count    = 0;
        quiet_cycles   = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed requests. A zero exponent must give one whatever the base, zero
        // included; zero raised to a positive power is zero; bases at or above the
        // prime must behave as their residue; the inverse of zero is zero and the
        // exponent must be disregarded in inverse mode.
        queue_request(1'b0, '0, '0);
        queue_request(1'b0, PRIME_MOD - BASE_W'(1), '0);
        queue_request(1'b0, '1, '0);
        queue_request(1'b0, '0, EXP_W'(1));
        queue_request(1'b0, '0, '1);
        queue_request(1'b0, BASE_W'(1), '1);
        queue_request(1'b0, PRIME_MOD - BASE_W'(1), '1);
        queue_request(1'b0, PRIME_MOD - BASE_W'(1), EXP_W'(2));
        queue_request(1'b0, '1, '1);
        queue_request(1'b0, PRIME_MOD, EXP_W'(5));
        queue_request(1'b0, PRIME_MOD + BASE_W'(1), EXP_W'(1));
        queue_request(1'b0, BASE_W'(3), FERMAT_EXP);
        queue_request(1'b0, BASE_W'(2), EXP_W'(1) << 30);
        queue_request(1'b1, '0, '0);
        queue_request(1'b1, '0, '1);
        queue_request(1'b1, BASE_W'(1), '0);
        queue_request(1'b1, BASE_W'(2), EXP_W'(7));
        queue_request(1'b1, PRIME_MOD - BASE_W'(1), '1);
        queue_request(1'b1, PRIME_MOD, '0);
        queue_request(1'b1, '1, EXP_W'($urandom));
        queue_request(1'b1, BASE_W'(12345), EXP_W'($urandom));

        // First phase: the sender idles now and then, the receiver most of the time.
        // Halfway through, the sender stops offering until everything has drained.
        for (int unsigned n = 0; n < RANDOM_PER_PHASE / 2; n++)
        begin
            queue_random_request();
        end
        wait_until_idle();
        for (int unsigned n = 0; n < RANDOM_PER_PHASE / 2; n++)
        begin
            queue_random_request();
        end
        wait_until_idle();

        // Second phase: the roles of the two sides are swapped.
        send_idle_pct = 82;
        recv_idle_pct = 24;
        for (int unsigned n = 0; n < RANDOM_PER_PHASE; n++)
        begin
            queue_random_request();
        end
        wait_until_idle();

        // Third phase: neither side idles. At its start the receiver holds off for a
        // long stretch while requests keep being offered, so the block fills up and
        // has to refuse further request beats.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int unsigned n = 0; n < RANDOM_PER_PHASE; n++)
        begin
            queue_random_request();
        end
        hold_orders = hold_orders + 1;
        wait_until_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0 && expected_residues.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
